[design/single_wire_humidity_frame_decoder_macros.svh]
// Assertion macros shared by the frame decoder modules.
`ifndef SINGLE_WIRE_HUMIDITY_FRAME_DECODER_MACROS_SVH
`define SINGLE_WIRE_HUMIDITY_FRAME_DECODER_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define SWHFD_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition must never be seen.
`define SWHFD_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

[design/swhfd_pkg.sv]
// Shared types, constants and helpers of the single-wire frame decoder.
package swhfd_pkg;

    localparam int GAP_WIDTH   = 10;
    localparam int DATA_GAPS   = 80;
    localparam int IDX_WIDTH   = $clog2(DATA_GAPS);
    localparam int SUM_WIDTH   = GAP_WIDTH + 1;
    localparam int REG_WIDTH   = 11;
    localparam int CMP_WIDTH   = (SUM_WIDTH > REG_WIDTH) ? SUM_WIDTH : REG_WIDTH;
    localparam int FRAME_BITS  = 40;
    localparam int POS_WIDTH   = $clog2(FRAME_BITS);
    localparam int CFG_IDX_WIDTH = 3;

    // command queue depth, power of two so pointers wrap on their own
    localparam int QDEPTH      = 2;
    localparam int QPTR_WIDTH  = $clog2(QDEPTH);
    localparam int QCNT_WIDTH  = $clog2(QDEPTH + 1);

    // configuration register indexes
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_START_MIN = 3'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_START_MAX = 3'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_ZERO_MIN  = 3'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_ZERO_MAX  = 3'd3;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_ONE_MIN   = 3'd4;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_ONE_MAX   = 3'd5;

    localparam logic [REG_WIDTH-1:0] RST_START_MIN = 11'd140;
    localparam logic [REG_WIDTH-1:0] RST_START_MAX = 11'd180;
    localparam logic [REG_WIDTH-1:0] RST_ZERO_MIN  = 11'd70;
    localparam logic [REG_WIDTH-1:0] RST_ZERO_MAX  = 11'd90;
    localparam logic [REG_WIDTH-1:0] RST_ONE_MIN   = 11'd110;
    localparam logic [REG_WIDTH-1:0] RST_ONE_MAX   = 11'd145;

    // frame status codes
    localparam logic [1:0] STATUS_GOOD   = 2'd0;
    localparam logic [1:0] STATUS_CKSUM  = 2'd1;
    localparam logic [1:0] STATUS_REJECT = 2'd2;

    typedef struct packed {
        logic                 wr_bit;
        logic [POS_WIDTH-1:0] bit_idx;
        logic                 zero_hit;
        logic                 one_hit;
        logic                 emit_frame;
        logic                 reject;
    } cmd_t;

    // strict open window test
    function automatic logic in_window(input logic [CMP_WIDTH-1:0] value,
                                       input logic [CMP_WIDTH-1:0] lo,
                                       input logic [CMP_WIDTH-1:0] hi);
        in_window = (value > lo) && (value < hi);
    endfunction

endpackage

[design/swhfd_front.sv]
// Front end: window registers, preamble search and gap pair classification.
`include "single_wire_humidity_frame_decoder_macros.svh"

module swhfd_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [swhfd_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
    input  logic [swhfd_pkg::REG_WIDTH-1:0]     cfg_data,
    input  logic                                gap_acc,
    input  logic [swhfd_pkg::GAP_WIDTH-1:0]     gap,
    output logic                                cmd_push,
    output swhfd_pkg::cmd_t                     cmd
);
    import swhfd_pkg::*;

    logic [REG_WIDTH-1:0] start_min_reg, start_max_reg;
    logic [REG_WIDTH-1:0] zero_min_reg, zero_max_reg;
    logic [REG_WIDTH-1:0] one_min_reg, one_max_reg;

    logic                 capturing_reg, capturing_next;
    logic [1:0]           pre_edges_reg, pre_edges_next;
    logic [SUM_WIDTH-1:0] pre_sum_reg, pre_sum_next;
    logic [IDX_WIDTH-1:0] gap_index_reg, gap_index_next;
    logic [GAP_WIDTH-1:0] held_gap_reg, held_gap_next;

    logic [SUM_WIDTH-1:0] pair_sum;
    logic [SUM_WIDTH-1:0] pre_total;
    logic [IDX_WIDTH-2:0] pair_num;
    logic                 last_gap;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_min_reg <= RST_START_MIN;
            start_max_reg <= RST_START_MAX;
            zero_min_reg  <= RST_ZERO_MIN;
            zero_max_reg  <= RST_ZERO_MAX;
            one_min_reg   <= RST_ONE_MIN;
            one_max_reg   <= RST_ONE_MAX;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_START_MIN: start_min_reg <= cfg_data;
                CFG_START_MAX: start_max_reg <= cfg_data;
                CFG_ZERO_MIN:  zero_min_reg  <= cfg_data;
                CFG_ZERO_MAX:  zero_max_reg  <= cfg_data;
                CFG_ONE_MIN:   one_min_reg   <= cfg_data;
                CFG_ONE_MAX:   one_max_reg   <= cfg_data;
                default:       ;
            endcase
        end
    end

    assign pair_sum  = SUM_WIDTH'(held_gap_reg) + SUM_WIDTH'(gap);
    assign pre_total = pre_sum_reg + SUM_WIDTH'(gap);
    assign pair_num  = gap_index_reg[IDX_WIDTH-1:1];
    assign last_gap  = (gap_index_reg == IDX_WIDTH'(DATA_GAPS - 1));

    always_comb
    begin
        capturing_next = capturing_reg;
        pre_edges_next = pre_edges_reg;
        pre_sum_next   = pre_sum_reg;
        gap_index_next = gap_index_reg;
        held_gap_next  = held_gap_reg;
        cmd            = '0;
        cmd.bit_idx    = POS_WIDTH'(FRAME_BITS - 1) - POS_WIDTH'(pair_num);
        cmd.zero_hit   = in_window(CMP_WIDTH'(pair_sum), CMP_WIDTH'(zero_min_reg),
                                   CMP_WIDTH'(zero_max_reg));
        cmd.one_hit    = in_window(CMP_WIDTH'(pair_sum), CMP_WIDTH'(one_min_reg),
                                   CMP_WIDTH'(one_max_reg));
        if (gap_acc)
        begin
            if (capturing_reg)
            begin
                // odd gap closes a pair
                if (gap_index_reg[0])
                    cmd.wr_bit = 1'b1;
                else
                    held_gap_next = gap;
                gap_index_next = gap_index_reg + IDX_WIDTH'(1);
                if (last_gap)
                begin
                    // frame-ending edge doubles as first preamble edge
                    capturing_next = 1'b0;
                    gap_index_next = '0;
                    pre_edges_next = 2'd1;
                    pre_sum_next   = '0;
                    cmd.emit_frame = 1'b1;
                end
            end
            else if (pre_edges_reg == 2'd0)
            begin
                pre_edges_next = 2'd1;
                pre_sum_next   = '0;
            end
            else if (pre_edges_reg == 2'd1)
            begin
                pre_edges_next = 2'd2;
                pre_sum_next   = pre_total;
            end
            else
            begin
                pre_edges_next = 2'd0;
                pre_sum_next   = '0;
                if (in_window(CMP_WIDTH'(pre_total), CMP_WIDTH'(start_min_reg),
                              CMP_WIDTH'(start_max_reg)))
                begin
                    capturing_next = 1'b1;
                    gap_index_next = '0;
                end
                else
                    cmd.reject = 1'b1;
            end
        end
    end

    assign cmd_push = cmd.wr_bit || cmd.emit_frame || cmd.reject;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capturing_reg <= 1'b0;
            pre_edges_reg <= 2'd0;
            pre_sum_reg   <= '0;
            gap_index_reg <= '0;
            held_gap_reg  <= '0;
        end
        else
        begin
            capturing_reg <= capturing_next;
            pre_edges_reg <= pre_edges_next;
            pre_sum_reg   <= pre_sum_next;
            gap_index_reg <= gap_index_next;
            held_gap_reg  <= held_gap_next;
        end
    end

    `SWHFD_ASSERT_IMPL(a_capture_clears_preamble, capturing_reg,
        (pre_edges_reg == 2'd0) && (pre_sum_reg == '0), "preamble state live during capture")
    `SWHFD_ASSERT_NEVER(a_gap_index_range, gap_index_reg > IDX_WIDTH'(DATA_GAPS - 1),
        "gap index past frame length")
    `SWHFD_ASSERT_IMPL(a_pre_edges_range, !capturing_reg, pre_edges_reg != 2'd3,
        "bad preamble edge count")

endmodule

[design/swhfd_cmd_queue.sv]
// Short command queue between front end and frame back end.
`include "single_wire_humidity_frame_decoder_macros.svh"

module swhfd_cmd_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  swhfd_pkg::cmd_t push_cmd,
    input  logic            pop,
    output logic            full,
    output logic            not_empty,
    output swhfd_pkg::cmd_t head_cmd
);
    import swhfd_pkg::*;

    cmd_t                  entry_reg [QDEPTH];
    logic [QPTR_WIDTH-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_WIDTH-1:0] count_reg, count_next;

    assign full      = (count_reg == QCNT_WIDTH'(QDEPTH));
    assign not_empty = (count_reg != '0);
    assign head_cmd  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + QCNT_WIDTH'(1);
        else if (pop && !push)
            count_next = count_reg - QCNT_WIDTH'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_WIDTH'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_WIDTH'(1);
            count_reg <= count_next;
        end
    end

    `SWHFD_ASSERT_NEVER(a_no_overflow, push && full, "push into full command queue")
    `SWHFD_ASSERT_NEVER(a_no_underflow, pop && !not_empty, "pop from empty command queue")
    `SWHFD_ASSERT_NEVER(a_count_range, count_reg > QCNT_WIDTH'(QDEPTH), "queue count overrun")

endmodule

[design/swhfd_back.sv]
// Back end: frame bit store, frame decode and result register.
`include "single_wire_humidity_frame_decoder_macros.svh"

module swhfd_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_avail,
    input  swhfd_pkg::cmd_t    cmd,
    output logic               cmd_pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         frame_status,
    output logic [15:0]        humidity_tenths,
    output logic signed [15:0] temperature_tenths,
    output logic [7:0]         checksum_received
);
    import swhfd_pkg::*;

    logic [FRAME_BITS-1:0] frame_reg, frame_next;
    logic                  out_valid_reg, out_valid_next;
    logic [1:0]            status_reg;
    logic [15:0]           humidity_reg;
    logic [15:0]           temp_reg;
    logic [7:0]            cksum_reg;

    logic                  has_result;
    logic                  out_free;
    logic [15:0]           tword;
    logic [15:0]           mag;
    logic [15:0]           temp_val;
    logic [7:0]            byte_sum;

    assign has_result = cmd.emit_frame || cmd.reject;
    assign out_free   = !out_valid_reg || !out_stall;
    assign cmd_pop    = cmd_avail && (!has_result || out_free);

    always_comb
    begin
        frame_next = frame_reg;
        if (cmd.wr_bit)
        begin
            // both windows hit: the one window wins, so the bit is set to 1
            if (cmd.zero_hit)
                frame_next[cmd.bit_idx] = 1'b0;
            if (cmd.one_hit)
                frame_next[cmd.bit_idx] = 1'b1;
        end
    end

    // sign-magnitude to two's complement; minus zero folds to zero
    assign tword    = frame_next[23:8];
    assign mag      = {1'b0, tword[14:0]};
    assign temp_val = tword[15] ? (16'd0 - mag) : mag;
    assign byte_sum = frame_next[39:32] + frame_next[31:24]
                    + frame_next[23:16] + frame_next[15:8];

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd_pop && has_result)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd_pop)
                frame_reg <= frame_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop && has_result)
        begin
            if (cmd.reject)
            begin
                status_reg   <= STATUS_REJECT;
                humidity_reg <= '0;
                temp_reg     <= '0;
                cksum_reg    <= '0;
            end
            else
            begin
                status_reg   <= (byte_sum == frame_next[7:0]) ? STATUS_GOOD : STATUS_CKSUM;
                humidity_reg <= frame_next[39:24];
                temp_reg     <= temp_val;
                cksum_reg    <= frame_next[7:0];
            end
        end
    end

    assign out_valid          = out_valid_reg;
    assign frame_status       = status_reg;
    assign humidity_tenths    = humidity_reg;
    assign temperature_tenths = temp_reg;
    assign checksum_received  = cksum_reg;

    `SWHFD_ASSERT_NEVER(a_result_not_lost, cmd_pop && has_result && out_valid_reg && out_stall,
        "result loaded over a stalled beat")
    `SWHFD_ASSERT_NEVER(a_one_result_kind, cmd.emit_frame && cmd.reject && cmd_avail,
        "command both emits and rejects")

endmodule

[design/single_wire_humidity_frame_decoder.sv]
// Top level of the single-wire humidity/temperature frame decoder.
//
//   channel   direction  handshake            payload
//   gap in    input      in_valid / in_stall  edge_gap_us
//   result    output     out_valid/out_stall  frame_status, humidity_tenths,
//                                             temperature_tenths, checksum_received
//   config    input      cfg_wr_en            cfg_index, cfg_data
//
// One edge gap accepted per cycle while in_stall is low; front end classifies it in the accept cycle.
// The gap that ends a frame or a rejected preamble yields a result beat via the command queue and result register.
// The two-entry command queue absorbs output stalls; in_stall rises only when it fills.
// Async active-low reset restores default windows and restarts the preamble search.
module single_wire_humidity_frame_decoder (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [swhfd_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
    input  logic [swhfd_pkg::REG_WIDTH-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [swhfd_pkg::GAP_WIDTH-1:0]     edge_gap_us,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [1:0]                          frame_status,
    output logic [15:0]                         humidity_tenths,
    output logic signed [15:0]                  temperature_tenths,
    output logic [7:0]                          checksum_received
);
    import swhfd_pkg::*;

    logic gap_acc;
    logic cmd_push;
    logic cmd_pop;
    logic q_full;
    logic q_not_empty;
    cmd_t front_cmd;
    cmd_t head_cmd;

    assign in_stall = q_full;
    assign gap_acc  = in_valid && !q_full;

    swhfd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .gap_acc   (gap_acc),
        .gap       (edge_gap_us),
        .cmd_push  (cmd_push),
        .cmd       (front_cmd)
    );

    swhfd_cmd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_cmd  (front_cmd),
        .pop       (cmd_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head_cmd  (head_cmd)
    );

    swhfd_back u_back (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd_avail          (q_not_empty),
        .cmd                (head_cmd),
        .cmd_pop            (cmd_pop),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .frame_status       (frame_status),
        .humidity_tenths    (humidity_tenths),
        .temperature_tenths (temperature_tenths),
        .checksum_received  (checksum_received)
    );

endmodule
